/* rtl/itoa_pkg.sv */
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and the digit-to-character lookup for the
// radix-to-ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int NUMBER_BITS_W = 32;
    localparam int VALUE_WIDTH   = 32;   // converted value width, at most NUMBER_BITS_W
    localparam int RADIX_W       = 6;
    localparam int DIGIT_W       = RADIX_W;
    localparam int CHAR_W        = 7;
    localparam int DIGIT_DEPTH   = VALUE_WIDTH;  // base 2 gives the longest string
    localparam int ADDR_W        = $clog2(DIGIT_DEPTH);
    localparam int CNT_W         = $clog2(DIGIT_DEPTH + 1);
    localparam int BIT_CNT_W     = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(36);
    localparam logic [DIGIT_W-1:0] DEC_DIGITS = DIGIT_W'(10);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] CHAR_A_LC  = CHAR_W'(8'h61);
    localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2d);
    localparam logic [CHAR_W-1:0] CHAR_NONE  = '0;

    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [DIGIT_W-1:0]     digit_t;
    typedef logic [RADIX_W-1:0]     radix_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BAD,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_SIGN,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic   start;
        value_t dividend;
        radix_t divisor;
    } div_cmd_t;

    typedef struct packed {
        logic   done;
        value_t quotient;
        digit_t remainder;
    } div_rsp_t;

    typedef struct packed {
        logic   en;
        addr_t  addr;
        digit_t data;
    } buf_wr_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } buf_rd_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input digit_t d);
        logic [CHAR_W-1:0] ch;
        if (d < DEC_DIGITS) begin
            ch = CHAR_ZERO + CHAR_W'(d);
        end else if (d < RADIX_MAX) begin
            ch = CHAR_A_LC + CHAR_W'(d - DEC_DIGITS);
        end else begin
            ch = CHAR_NONE;
        end
        return ch;
    endfunction

endpackage

/* rtl/itoa_div.sv */
// ----------------------------------------------------------------------------
// itoa_div
// Restoring divider, one quotient bit per cycle. Divides the running
// quotient by the base and returns quotient and remainder.
// ----------------------------------------------------------------------------
module itoa_div (
    input  logic             aclk,
    input  logic             aresetn,
    input  itoa_pkg::div_cmd_t cmd,
    output itoa_pkg::div_rsp_t rsp
);
    import itoa_pkg::*;

    value_t               q_reg;
    digit_t               rem_reg;
    radix_t               div_reg;
    logic [BIT_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIGIT_W:0] trial;
    logic [DIGIT_W:0] diff;
    logic             ge;
    digit_t           rem_next;
    logic             cnt_last;

    always_comb begin
        trial    = {rem_reg, q_reg[VALUE_WIDTH-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = trial >= {1'b0, div_reg};
        // partial remainder stays below the divisor, so it fits DIGIT_W bits
        rem_next = ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
    end

    assign cnt_last = (cnt_reg == BIT_CNT_W'(VALUE_WIDTH - 1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= !cmd.start && busy_reg && cnt_last;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_last) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_reg   <= cmd.dividend;
            rem_reg <= '0;
            div_reg <= cmd.divisor;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[VALUE_WIDTH-2:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* rtl/itoa_digit_buf.sv */
// ----------------------------------------------------------------------------
// itoa_digit_buf
// Digit store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module itoa_digit_buf (
    input  logic              aclk,
    input  itoa_pkg::buf_wr_t wr,
    input  itoa_pkg::buf_rd_t rd,
    output itoa_pkg::digit_t  rd_data
);
    import itoa_pkg::*;

    digit_t mem [DIGIT_DEPTH];
    digit_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/itoa_ctrl.sv */
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: takes an item, runs the divider once per digit, then plays the
// stored digits back in reverse through the output register.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [31:0]          s_number_bits,
    input  logic                 s_signed_mode,
    input  logic [5:0]           s_radix,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [6:0]           m_ascii_char,
    output logic                 m_last_char,
    output logic                 m_bad_radix,
    output itoa_pkg::div_cmd_t   div_cmd,
    input  itoa_pkg::div_rsp_t   div_rsp,
    output itoa_pkg::buf_wr_t    buf_wr,
    output itoa_pkg::buf_rd_t    buf_rd,
    input  itoa_pkg::digit_t     buf_rd_data
);
    import itoa_pkg::*;

    ctrl_state_t state_reg, state_next;

    value_t           quot_reg;
    radix_t           radix_reg;
    logic [CNT_W-1:0] count_reg;
    logic             neg_reg;

    logic              out_valid_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_last_reg;
    logic              out_bad_reg;

    logic              in_xfer;
    logic              in_bad;
    logic              in_neg;
    value_t            in_val;
    logic              out_free;
    logic              div_last;
    logic [CNT_W-1:0]  count_inc;
    logic [CNT_W-1:0]  count_dec;

    logic              load_item;
    logic              store_digit;
    logic              out_load;
    logic [CHAR_W-1:0] out_char_next;
    logic              out_last_next;
    logic              out_bad_next;
    logic              emit_digit;

    assign in_xfer   = s_valid && s_ready;
    assign in_bad    = (s_radix < RADIX_MIN) || (s_radix > RADIX_MAX);
    assign in_val    = s_number_bits[VALUE_WIDTH-1:0];
    assign in_neg    = s_signed_mode && in_val[VALUE_WIDTH-1];
    assign out_free  = !out_valid_reg || m_ready;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    // stop on a zero quotient or a full store
    assign div_last  = (div_rsp.quotient == '0) || (count_inc == CNT_W'(DIGIT_DEPTH));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    state_next = in_bad ? ST_BAD : ST_DIV_START;
                end
            end
            ST_BAD: begin
                if (out_free) state_next = ST_IDLE;
            end
            ST_DIV_START: begin
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (!div_last)    state_next = ST_DIV_START;
                    else if (neg_reg) state_next = ST_SIGN;
                    else              state_next = ST_READ;
                end
            end
            ST_SIGN: begin
                if (out_free) state_next = ST_READ;
            end
            ST_READ: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    state_next = (count_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready       = 1'b0;
        load_item     = 1'b0;
        store_digit   = 1'b0;
        out_load      = 1'b0;
        out_char_next = CHAR_NONE;
        out_last_next = 1'b0;
        out_bad_next  = 1'b0;
        emit_digit    = 1'b0;
        div_cmd.start    = 1'b0;
        div_cmd.dividend = quot_reg;
        div_cmd.divisor  = radix_reg;
        buf_rd.en   = 1'b0;
        buf_rd.addr = count_dec[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                load_item = in_xfer && !in_bad;
            end
            ST_BAD: begin
                out_load      = out_free;
                out_char_next = CHAR_NONE;
                out_last_next = 1'b1;
                out_bad_next  = 1'b1;
            end
            ST_DIV_START: begin
                div_cmd.start = 1'b1;
            end
            ST_DIV_WAIT: begin
                store_digit = div_rsp.done;
            end
            ST_SIGN: begin
                out_load      = out_free;
                out_char_next = CHAR_MINUS;
            end
            ST_READ: begin
                buf_rd.en = 1'b1;
            end
            ST_EMIT: begin
                out_load      = out_free;
                emit_digit    = out_free;
                out_char_next = digit_to_ascii(buf_rd_data);
                out_last_next = (count_reg == CNT_W'(1));
            end
            default: ;
        endcase
    end

    assign buf_wr.en   = store_digit;
    assign buf_wr.addr = count_reg[ADDR_W-1:0];
    assign buf_wr.data = div_rsp.remainder;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            quot_reg      <= '0;
            count_reg     <= '0;
            neg_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (load_item) begin
                quot_reg  <= in_neg ? (~in_val + 1'b1) : in_val;
                count_reg <= '0;
                neg_reg   <= in_neg;
            end else if (store_digit) begin
                quot_reg  <= div_rsp.quotient;
                count_reg <= count_inc;
            end else if (emit_digit) begin
                count_reg <= count_dec;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_item) begin
            radix_reg <= s_radix;
        end
        if (out_load) begin
            out_char_reg <= out_char_next;
            out_last_reg <= out_last_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_ascii_char = out_char_reg;
    assign m_last_char  = out_last_reg;
    assign m_bad_radix  = out_bad_reg;

endmodule

/* rtl/integer_to_radix_ascii_core.sv */
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts a 32-bit value to ASCII digits in base 2..36, MSD first.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one transfer carries the value, the signed flag and the
//   base. s_ready is high only while the block is idle.
//   Result channel m_*: one transfer per character, MSD first, lower-case
//   letters above nine, a leading '-' for negative signed values. The final
//   character has m_last_char set. A base outside 2..36 gives one transfer
//   with m_bad_radix and m_last_char set and m_ascii_char zero.
//   Timing: each digit takes one pass of the shared bit-serial divider
//   (one quotient bit per cycle over 32 bits, plus start and write-back),
//   then each character on playback takes a store read and an output load.
//   Stall: the output register holds the character until m_ready; playback
//   pauses meanwhile. The next item is taken as soon as the last character
//   sits in the output register.
//   Reset (aresetn low, synchronous) clears the sequencer and the output
//   valid; the digit store needs no clearing.
// ----------------------------------------------------------------------------
module integer_to_radix_ascii_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_number_bits,
    input  logic        s_signed_mode,
    input  logic [5:0]  s_radix,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_ascii_char,
    output logic        m_last_char,
    output logic        m_bad_radix
);
    import itoa_pkg::*;

    div_cmd_t div_cmd;
    div_rsp_t div_rsp;
    buf_wr_t  buf_wr;
    buf_rd_t  buf_rd;
    digit_t   buf_rd_data;

    itoa_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_number_bits (s_number_bits),
        .s_signed_mode (s_signed_mode),
        .s_radix       (s_radix),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .m_last_char   (m_last_char),
        .m_bad_radix   (m_bad_radix),
        .div_cmd       (div_cmd),
        .div_rsp       (div_rsp),
        .buf_wr        (buf_wr),
        .buf_rd        (buf_rd),
        .buf_rd_data   (buf_rd_data)
    );

    itoa_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (div_cmd),
        .rsp     (div_rsp)
    );

    itoa_digit_buf u_buf (
        .aclk    (aclk),
        .wr      (buf_wr),
        .rd      (buf_rd),
        .rd_data (buf_rd_data)
    );

endmodule

/* rtl/itoa_checker.sv */
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level assertions for the radix-to-ASCII converter, bound to the top.
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [6:0] m_ascii_char,
    input logic       m_last_char,
    input logic       m_bad_radix
);

    // a bad-base result is a single empty character
    a_bad_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_bad_radix) |-> (m_last_char && (m_ascii_char == 7'd0)))
        else $error("bad-base result malformed");

    // one item at a time: busy right after an input transfer
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while busy");

    // no new item while a string is still being delivered
    a_no_take_mid_string: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last_char) |-> !s_ready)
        else $error("ready during string playback");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=>
            (m_valid && $stable(m_ascii_char) && $stable(m_last_char)
             && $stable(m_bad_radix)))
        else $error("result changed under stall");

endmodule

bind integer_to_radix_ascii_core itoa_checker u_itoa_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_ascii_char (m_ascii_char),
    .m_last_char  (m_last_char),
    .m_bad_radix  (m_bad_radix)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_radix_ascii_core. Directed numbers cover
// bad bases, zero, the most negative value and range extremes in several bases. A
// random phase follows with burst/gap input traffic and a varying m_ready
// stall pattern. Every character is checked against a predicted queue.
// ----------------------------------------------------------------------------
module tb_top;

    import itoa_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RANDOM_ITEMS = 480;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int SETTLE_CYCLES = 100;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              bad;
    } char_exp_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_number_bits;
    logic        s_signed_mode;
    logic [5:0]  s_radix;
    logic        m_valid;
    logic        m_ready;
    logic [6:0]  m_ascii_char;
    logic        m_last_char;
    logic        m_bad_radix;

    char_exp_t pending_chars[$];
    int        mismatch_count;
    int        burst_left;

    // predictor state
    value_t    conv_quotient;
    int        conv_count;
    logic      conv_negative;
    digit_t    conv_digits[64];

    integer_to_radix_ascii_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_number_bits (s_number_bits),
        .s_signed_mode (s_signed_mode),
        .s_radix       (s_radix),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_ascii_char  (m_ascii_char),
        .m_last_char   (m_last_char),
        .m_bad_radix   (m_bad_radix)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    initial begin
        #(64'd50_000_000);
        $display("tb: failure");
        $finish;
    end

    function automatic logic [CHAR_W-1:0] glyph_of(input digit_t d);
        logic [CHAR_W-1:0] g;
        if (d < 10) begin
            g = 7'h30 + CHAR_W'(d);
        end else if (d < 36) begin
            g = 7'h61 + CHAR_W'(d) - 7'd10;
        end else begin
            g = '0;
        end
        return g;
    endfunction

    // Expected characters for one accepted number, appended to pending_chars.
    function automatic void predict_digits(input logic [31:0] num, input logic sgn,
                                           input radix_t radix);
        value_t    mag;
        value_t    base;
        char_exp_t item;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            item.ch   = CHAR_NONE;
            item.last = 1'b1;
            item.bad  = 1'b1;
            pending_chars.push_back(item);
            return;
        end
        mag  = value_t'(num);
        base = value_t'(radix);
        conv_negative = sgn && mag[VALUE_WIDTH-1];
        if (conv_negative) begin
            mag = ~mag + 1'b1;
        end
        conv_quotient = mag;
        conv_count    = 0;
        do begin
            conv_digits[conv_count] = digit_t'(conv_quotient % base);
            conv_count++;
            conv_quotient = conv_quotient / base;
        end while (conv_quotient != 0 && conv_count < 64);
        if (conv_negative) begin
            item.ch   = CHAR_MINUS;
            item.last = 1'b0;
            item.bad  = 1'b0;
            pending_chars.push_back(item);
        end
        for (int i = conv_count; i > 0; i--) begin
            item.ch   = glyph_of(conv_digits[i-1]);
            item.last = (i == 1);
            item.bad  = 1'b0;
            pending_chars.push_back(item);
        end
    endfunction

    // One input transfer; called and returns at a falling edge. Valid stays up
    // between back-to-back calls inside a burst.
    task automatic push_number(input logic [31:0] num, input logic sgn, input radix_t radix);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid       = 1'b0;
                s_number_bits = $urandom;
                s_signed_mode = 1'($urandom_range(0, 1));
                s_radix       = 6'($urandom_range(0, 63));
                repeat (gap) @(negedge aclk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       = 1'b1;
        s_number_bits = num;
        s_signed_mode = sgn;
        s_radix       = radix;
        do @(posedge aclk); while (!s_ready);
        predict_digits(num, sgn, radix);
        @(negedge aclk);
    endtask

    // Receiver stall pattern: the mode is redrawn at random whenever its run ends.
    initial begin
        int mode;
        int mode_left;
        int hold;
        m_ready   = 1'b0;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        forever begin
            @(negedge aclk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0: m_ready = 1'b1;
                1: m_ready = 1'($urandom_range(0, 1));
                2: m_ready = ($urandom_range(0, 3) == 0);
                default: begin
                    if (hold == 0) begin
                        m_ready = 1'b1;
                        hold    = $urandom_range(0, 15);
                    end else begin
                        m_ready = 1'b0;
                        hold--;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        char_exp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_chars.size() == 0) begin
                $display("%0t: unexpected transfer char=%h last=%b bad=%b", $time,
                         m_ascii_char, m_last_char, m_bad_radix);
                mismatch_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_ascii_char !== want.ch) begin
                    $display("%0t: ascii_char expected %h actual %h", $time,
                             want.ch, m_ascii_char);
                    mismatch_count++;
                end
                if (m_last_char !== want.last) begin
                    $display("%0t: last_char expected %b actual %b", $time,
                             want.last, m_last_char);
                    mismatch_count++;
                end
                if (m_bad_radix !== want.bad) begin
                    $display("%0t: bad_radix expected %b actual %b", $time,
                             want.bad, m_bad_radix);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic test_bad_radix();
        push_number(32'd123, 1'b0, 6'd0);
        push_number(32'hFFFF_FFFF, 1'b1, 6'd1);
        push_number(32'd5, 1'b0, 6'd37);
        push_number(32'h8000_0000, 1'b1, 6'd63);
    endtask

    task automatic test_zero_value();
        push_number(32'd0, 1'b0, 6'd2);
        push_number(32'd0, 1'b1, 6'd10);
        push_number(32'd0, 1'b1, 6'd36);
    endtask

    task automatic test_most_negative();
        push_number(32'h8000_0000, 1'b1, 6'd2);
        push_number(32'h8000_0000, 1'b1, 6'd10);
        push_number(32'h8000_0000, 1'b1, 6'd36);
        push_number(32'h8000_0000, 1'b0, 6'd16);
    endtask

    task automatic test_range_extremes();
        push_number(32'hFFFF_FFFF, 1'b0, 6'd2);
        push_number(32'hFFFF_FFFF, 1'b1, 6'd10);
        push_number(32'hFFFF_FFFF, 1'b0, 6'd36);
        push_number(32'h7FFF_FFFF, 1'b1, 6'd2);
        push_number(32'd35, 1'b0, 6'd36);
        push_number(32'd36, 1'b0, 6'd36);
        push_number(32'hDEAD_BEEF, 1'b0, 6'd16);
        push_number(32'hDEAD_BEEF, 1'b1, 6'd16);
        push_number(32'd1, 1'b0, 6'd2);
        push_number(32'd255, 1'b1, 6'd3);
    endtask

    task automatic test_random_numbers();
        logic [31:0] num;
        logic [31:0] pw;
        radix_t      radix;
        int          k;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if ($urandom_range(0, 9) == 0) begin
                // bad base, mostly just outside the legal range
                case ($urandom_range(0, 2))
                    0: radix = radix_t'($urandom_range(0, 1));
                    1: radix = 6'd37;
                    default: radix = radix_t'($urandom_range(37, 63));
                endcase
            end else begin
                case ($urandom_range(0, 5))
                    0: radix = 6'd2;
                    1: radix = 6'd10;
                    2: radix = 6'd16;
                    3: radix = 6'd36;
                    default: radix = radix_t'($urandom_range(2, 36));
                endcase
            end
            case ($urandom_range(0, 6))
                0: num = $urandom_range(0, 35);
                1: num = $urandom_range(0, 2000);
                2: begin
                    // around a power of the base
                    pw = 32'd1;
                    k  = $urandom_range(1, 31);
                    repeat (k) pw = pw * 32'(radix);
                    num = pw + 32'($urandom_range(0, 2)) - 32'd1;
                end
                3: begin
                    case ($urandom_range(0, 4))
                        0: num = 32'h0000_0000;
                        1: num = 32'h8000_0000;
                        2: num = 32'h7FFF_FFFF;
                        3: num = 32'hFFFF_FFFF;
                        default: num = 32'h8000_0001;
                    endcase
                end
                4: num = -$urandom_range(1, 5000);
                default: num = $urandom;
            endcase
            push_number(num, 1'($urandom_range(0, 1)), radix);
        end
    endtask

    initial begin
        int waited;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_number_bits  = '0;
        s_signed_mode  = 1'b0;
        s_radix        = '0;
        mismatch_count = 0;
        burst_left     = 0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_bad_radix();
        test_zero_value();
        test_most_negative();
        test_range_extremes();
        test_random_numbers();
        s_valid = 1'b0;

        waited = 0;
        while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_chars.size() != 0) begin
            $display("%0t: %0d characters never arrived", $time, pending_chars.size());
            $display("tb: failure");
            $finish;
        end else begin
            repeat (SETTLE_CYCLES) @(posedge aclk);
            if (mismatch_count == 0) begin
                $display("tb: success");
            end else begin
                $display("tb: failure");
            end
            $finish;
        end
    end

endmodule
